FILE: hdl/proportional_text_layout_assert.svh
// assertion macros for the proportional text layout block
`ifndef PROPORTIONAL_TEXT_LAYOUT_ASSERT_SVH
`define PROPORTIONAL_TEXT_LAYOUT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ptl_pkg.sv
// types and constants shared by the text layout block and its interfaces
`default_nettype none

package ptl_pkg;

	// command opcodes
	localparam logic [1:0] OP_TABLE_WR = 2'd0;
	localparam logic [1:0] OP_START    = 2'd1;
	localparam logic [1:0] OP_CHAR     = 2'd2;
	localparam logic [1:0] OP_END      = 2'd3;

	// result kinds
	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_BOUNDS = 1'b1;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [15:0] GLYPH_GAP    = 16'd1;
	localparam logic [15:0] FONT_HEIGHT_RST = 16'd8;

	// one command item
	typedef struct packed {
		logic [1:0]  op;
		logic [8:0]  table_index;
		logic [15:0] offset_value;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [7:0]  char_code;
	} ptl_cmd_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [15:0] source_x;
		logic [15:0] dest_x;
		logic [15:0] dest_y;
		logic [15:0] glyph_width;
		logic        missing_glyph;
		logic [15:0] bound_x;
		logic [15:0] bound_y;
	} ptl_res_t;

endpackage

`default_nettype wire

FILE: hdl/ptl_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none

interface ptl_cmd_if import ptl_pkg::*; ();
	logic     valid;
	logic     ready;
	ptl_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptl_res_if import ptl_pkg::*; ();
	logic     valid;
	logic     ready;
	ptl_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/proportional_text_layout.sv
// proportional font text layout: offset table, pen state and result register
//
// Usage: commands arrive on the cmd channel (valid/ready, transfer when both
// are high). Opcode 0 loads one glyph offset table entry, 1 starts a string
// at a pen position, 2 lays out one character, 3 ends the string. Each
// non-newline character yields one glyph blit result, the end command
// yields one bounds result, all other commands yield nothing. Results leave
// on the res channel with the same handshake. font_height is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, since
// the block does not enforce this. A command enters the table read stage at
// its transfer, and its result enters the output register as the read stage
// moves on. Throughput: one command per cycle while results drain, set by the
// two-port table read register feeding a single add stage that updates the
// pen. The table read stage keeps accepting while a result waits in the
// output register; cmd ready drops only when the read stage holds a command
// that yields a result, the output register is full and the receiver stalls.
// Reset clears the pen, line start, max x, font height (to 8) and all valid
// flags; the offset table holds no reset value and must be loaded before use.
`default_nettype none
`include "proportional_text_layout_assert.svh"

module proportional_text_layout
	import ptl_pkg::*;
#(
	parameter int TABLE_DEPTH = 257
) (
	input  wire         clk,
	input  wire         arst_n,
	ptl_cmd_if.sink     cmd,
	ptl_res_if.source   res,
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [9:0] DEPTH_V = 10'(TABLE_DEPTH);

	// glyph offset table, no reset
	logic [15:0] offset_mem [TABLE_DEPTH];

	logic        cmd_xfer;
	logic        tbl_wr;
	logic [8:0]  ch_cur;
	logic [8:0]  ch_next;
	logic        lo_in_range;
	logic        hi_in_range;

	// table read stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  ch_s1;
	logic [15:0] sx_s1;
	logic [15:0] sy_s1;
	logic        lo_zero_s1;
	logic        hi_zero_s1;
	logic [15:0] rd_lo_s1;
	logic [15:0] rd_hi_s1;

	logic        s1_is_nl;
	logic        s1_has_res;
	logic        s1_moves;

	// pen state
	logic [15:0] pen_x_q;
	logic [15:0] pen_y_q;
	logic [15:0] line_start_x_q;
	logic [15:0] max_x_q;
	logic [15:0] font_height_q;

	logic        res_valid_q;
	ptl_res_t    res_q;

	logic [15:0] src_x;
	logic [15:0] hi_x;
	logic [15:0] width;
	logic [15:0] widest_x;
	logic [15:0] line_y_end;
	ptl_res_t    res_d;

	// input handshake and table addressing
	assign s1_is_nl   = (op_s1 == OP_CHAR) && (ch_s1 == NEWLINE_CODE);
	assign s1_has_res = ((op_s1 == OP_CHAR) && !s1_is_nl) || (op_s1 == OP_END);
	assign s1_moves   = valid_s1 && (!s1_has_res || !res_valid_q || res.ready);
	assign cmd.ready  = !valid_s1 || s1_moves;
	assign cmd_xfer   = cmd.valid && cmd.ready;

	assign ch_cur      = {1'b0, cmd.data.char_code};
	assign ch_next     = ch_cur + 9'd1;
	assign lo_in_range = {1'b0, ch_cur} < DEPTH_V;
	assign hi_in_range = {1'b0, ch_next} < DEPTH_V;
	assign tbl_wr      = cmd_xfer && (cmd.data.op == OP_TABLE_WR)
		&& ({1'b0, cmd.data.table_index} < DEPTH_V);

	// table write and two-port registered read
	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			offset_mem[cmd.data.table_index[IDX_W-1:0]] <= cmd.data.offset_value;
		end
		if (cmd_xfer) begin
			rd_lo_s1 <= offset_mem[ch_cur[IDX_W-1:0]];
			rd_hi_s1 <= offset_mem[ch_next[IDX_W-1:0]];
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_s1      <= cmd.data.op;
			ch_s1      <= cmd.data.char_code;
			sx_s1      <= cmd.data.start_x;
			sy_s1      <= cmd.data.start_y;
			lo_zero_s1 <= !lo_in_range;
			hi_zero_s1 <= !hi_in_range;
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// glyph width, bounds and result assembly
	assign src_x      = lo_zero_s1 ? 16'd0 : rd_lo_s1;
	assign hi_x       = hi_zero_s1 ? 16'd0 : rd_hi_s1;
	assign width      = hi_x - src_x;
	assign widest_x   = (pen_x_q > max_x_q) ? pen_x_q : max_x_q;
	assign line_y_end = pen_y_q + font_height_q;

	always_comb begin
		res_d = '0;
		if (op_s1 == OP_END) begin
			res_d.kind    = KIND_BOUNDS;
			res_d.bound_x = widest_x;
			res_d.bound_y = line_y_end;
		end else begin
			res_d.kind          = KIND_GLYPH;
			res_d.source_x      = src_x;
			res_d.dest_x        = pen_x_q;
			res_d.dest_y        = pen_y_q;
			res_d.glyph_width   = width;
			res_d.missing_glyph = (width == 16'd0);
		end
	end

	// pen state and font height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q        <= '0;
			pen_y_q        <= '0;
			line_start_x_q <= '0;
			max_x_q        <= '0;
			font_height_q  <= FONT_HEIGHT_RST;
		end else begin
			if (cfg_we) begin
				font_height_q <= cfg_wdata;
			end
			if (s1_moves) begin
				case (op_s1)
					OP_START: begin
						pen_x_q        <= sx_s1;
						pen_y_q        <= sy_s1;
						line_start_x_q <= sx_s1;
						max_x_q        <= '0;
					end
					OP_CHAR: begin
						if (s1_is_nl) begin
							max_x_q <= widest_x;
							pen_x_q <= line_start_x_q;
							pen_y_q <= line_y_end;
						end else begin
							pen_x_q <= pen_x_q + width + GLYPH_GAP;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_moves && s1_has_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_moves && s1_has_res) begin
			res_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// checks
	`PTL_ASSERT_NOW(a_no_overwrite, s1_moves && s1_has_res, !res_valid_q || res.ready, "result register overwritten while full")
	`PTL_ASSERT_NOW(a_missing_flag, res.valid && (res.data.kind == KIND_GLYPH), res.data.missing_glyph == (res.data.glyph_width == 16'd0), "missing glyph flag disagrees with width")
	`PTL_ASSERT_NEXT(a_newline_pen, s1_moves && s1_is_nl, pen_x_q == $past(line_start_x_q), "newline did not return pen to line start")
	`PTL_ASSERT_NEXT(a_stall_hold, valid_s1 && !s1_moves, valid_s1 && $stable(op_s1), "stalled read stage lost its item")

endmodule

`default_nettype wire

FILE: tb/sv/tb_proportional_text_layout.sv
// self-checking testbench for the proportional text layout block
`default_nettype none

module tb_proportional_text_layout;
	import ptl_pkg::*;

	localparam int GLYPH_SLOTS = 257;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 90;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	ptl_cmd_if cmd_ch ();
	ptl_res_if res_ch ();

	proportional_text_layout #(.TABLE_DEPTH(GLYPH_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// layout state mirrored from the block
	logic [15:0] glyph_col [0:GLYPH_SLOTS-1];
	logic [15:0] pen_x, pen_y, line_x, widest_x;
	logic [15:0] font_h = FONT_HEIGHT_RST;

	ptl_cmd_t pending_cmds [$];
	ptl_res_t expected_layout_out [$];
	int       cmds_queued = 0;
	int       cmds_taken = 0;
	int       mismatch_count = 0;
	logic     cmd_took = 1'b0;

	// sender burst state
	int burst_left = 0;
	int gap_left = 0;

	// receiver stall state
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       hold_left = 0;
	int       holds_asked = 0;
	int       holds_served = 0;

	initial begin
		pen_x = '0;
		pen_y = '0;
		line_x = '0;
		widest_x = '0;
	end

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("tb_proportional_text_layout NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// expected result of one command, updating the mirrored layout state
	function automatic bit predict_layout(input ptl_cmd_t c, output ptl_res_t r);
		logic [15:0] col;
		logic [15:0] w;
		int          idx;
		r = '0;
		idx = int'(c.char_code);
		case (c.op)
			OP_TABLE_WR: begin
				if (int'(c.table_index) < GLYPH_SLOTS)
					glyph_col[c.table_index] = c.offset_value;
				return 1'b0;
			end
			OP_START: begin
				pen_x = c.start_x;
				pen_y = c.start_y;
				line_x = c.start_x;
				widest_x = '0;
				return 1'b0;
			end
			OP_CHAR: begin
				// newline: back to line start, one row down
				if (c.char_code == NEWLINE_CODE) begin
					if (pen_x > widest_x)
						widest_x = pen_x;
					pen_x = line_x;
					pen_y = pen_y + font_h;
					return 1'b0;
				end
				col = glyph_col[idx];
				w = glyph_col[idx + 1] - col;
				r.kind = KIND_GLYPH;
				r.source_x = col;
				r.dest_x = pen_x;
				r.dest_y = pen_y;
				r.glyph_width = w;
				r.missing_glyph = (w == 16'd0);
				pen_x = pen_x + w + GLYPH_GAP;
				return 1'b1;
			end
			default: begin
				r.kind = KIND_BOUNDS;
				r.bound_x = (pen_x > widest_x) ? pen_x : widest_x;
				r.bound_y = pen_y + font_h;
				return 1'b1;
			end
		endcase
	endfunction

	// command with every field random, then the op set
	function automatic ptl_cmd_t fill_cmd(input logic [1:0] op);
		ptl_cmd_t c;
		c.table_index = 9'($urandom);
		c.offset_value = 16'($urandom);
		c.start_x = 16'($urandom);
		c.start_y = 16'($urandom);
		c.char_code = 8'($urandom);
		c.op = op;
		return c;
	endfunction

	task automatic queue_cmd(input ptl_cmd_t c);
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic put_write(input int idx, input logic [15:0] val);
		ptl_cmd_t c;
		c = fill_cmd(OP_TABLE_WR);
		c.table_index = 9'(idx);
		c.offset_value = val;
		queue_cmd(c);
	endtask

	task automatic put_start(input logic [15:0] x, input logic [15:0] y);
		ptl_cmd_t c;
		c = fill_cmd(OP_START);
		c.start_x = x;
		c.start_y = y;
		queue_cmd(c);
	endtask

	task automatic put_char(input logic [7:0] ch);
		ptl_cmd_t c;
		c = fill_cmd(OP_CHAR);
		c.char_code = ch;
		queue_cmd(c);
	endtask

	task automatic put_end();
		queue_cmd(fill_cmd(OP_END));
	endtask

	// random text: mostly whole strings, some table rewrites and stray commands
	task automatic queue_random_text(input int n);
		int          added;
		int          len;
		int          pick;
		logic [15:0] x, y;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				case ($urandom_range(0, 3))
					0: begin
						x = '0;
						y = '0;
					end
					1: begin
						x = 16'hFFF0 | 16'($urandom_range(0, 15));
						y = 16'hFFF0 | 16'($urandom_range(0, 15));
					end
					default: begin
						x = 16'($urandom);
						y = 16'($urandom);
					end
				endcase
				put_start(x, y);
				len = $urandom_range(0, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 15)
						put_char(NEWLINE_CODE);
					else
						put_char(8'($urandom_range(0, 255)));
				end
				put_end();
				added += len + 2;
				if ($urandom_range(0, 9) == 0) begin
					put_end();
					added++;
				end
			end else if (pick < 87) begin
				if ($urandom_range(0, 4) == 0)
					put_write($urandom_range(GLYPH_SLOTS, 511), 16'($urandom));
				else
					put_write($urandom_range(0, GLYPH_SLOTS - 1), 16'($urandom));
				added++;
			end else begin
				case ($urandom_range(0, 2))
					0: put_char(8'($urandom_range(0, 255)));
					1: put_char(NEWLINE_CODE);
					default: put_end();
				endcase
				added++;
			end
		end
	endtask

	// wait until every command is taken and every result has come back
	task automatic wait_drained();
		while (cmds_taken != cmds_queued || expected_layout_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_font_height(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		font_h = v;
	endtask

	// command driver: bursts of transfers with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_took) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.data <= pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: stall pattern picked at random among four modes, plus long holds
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (rx_mode_left == 0) begin
			rx_mode_left = $urandom_range(16, 96);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		end else begin
			rx_mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   res_ch.ready <= 1'b1;
				RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   res_ch.ready <= ~res_ch.ready;
			endcase
		end
	end

	// monitor: predict on command transfer, compare on result transfer
	always @(posedge clk) begin : monitor
		ptl_res_t want;
		ptl_res_t fresh;
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_ch.valid && cmd_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				if (expected_layout_out.size() == 0) begin
					report_mismatch("result with nothing outstanding");
				end else begin
					want = expected_layout_out.pop_front();
					check_field("kind", 16'(res_ch.data.kind), 16'(want.kind));
					check_field("source_x", res_ch.data.source_x, want.source_x);
					check_field("dest_x", res_ch.data.dest_x, want.dest_x);
					check_field("dest_y", res_ch.data.dest_y, want.dest_y);
					check_field("glyph_width", res_ch.data.glyph_width, want.glyph_width);
					check_field("missing_glyph", 16'(res_ch.data.missing_glyph),
						16'(want.missing_glyph));
					check_field("bound_x", res_ch.data.bound_x, want.bound_x);
					check_field("bound_y", res_ch.data.bound_y, want.bound_y);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_taken++;
				if (predict_layout(cmd_ch.data, fresh))
					expected_layout_out.push_back(fresh);
			end
		end
	end

	// stimulus and phase control
	initial begin : stimulus
		logic [15:0] col;
		logic [15:0] heights [5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// load every table entry; zero width at 'A', wrapping width at 200
		col = 16'($urandom_range(0, 100));
		for (int i = 0; i < GLYPH_SLOTS; i++) begin
			if (i == 66)
				col = col;
			else if (i == 201)
				col = col - 16'd5;
			else if (i % 40 == 0)
				col = 16'($urandom);
			else
				col = col + 16'($urandom_range(0, 12));
			put_write(i, col);
		end

		// directed: no start, extremes, newline, repeated end, ignored writes
		put_char(8'd65);
		put_end();
		put_char(NEWLINE_CODE);
		put_start(16'hFFFF, 16'hFFFF);
		put_char(8'd255);
		put_char(8'd200);
		put_char(NEWLINE_CODE);
		put_char(8'd0);
		put_end();
		put_end();
		put_write(256, 16'hFFFF);
		put_write(257, 16'h0000);
		put_write(511, 16'h1234);
		put_write(0, 16'h0000);
		put_char(8'd255);
		put_start(16'h0000, 16'h0000);
		put_char(8'd65);
		put_char(NEWLINE_CODE);
		put_char(NEWLINE_CODE);
		put_char(8'd0);
		put_end();
		put_write(65, 16'hFFFF);
		put_char(8'd64);
		put_end();
		queue_random_text(100);
		wait_drained();

		// random text under several font heights
		heights[0] = 16'd0;
		heights[1] = 16'hFFFF;
		heights[2] = 16'd1;
		heights[3] = 16'($urandom);
		heights[4] = FONT_HEIGHT_RST;
		for (int p = 0; p < 5; p++) begin
			set_font_height(heights[p]);
			queue_random_text(75);
			if (p == 1 || p == 3)
				holds_asked++;
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("tb_proportional_text_layout OK");
		else
			$display("tb_proportional_text_layout NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
